/* hw/rtl/pfb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfb_pkg
// Shared types and constants of the polyphase FIR filter bank.
// ----------------------------------------------------------------------------
package pfb_pkg;

	localparam int OP_W        = 2;
	localparam int BANK_W      = 5;
	localparam int TAP_W       = 4;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int BANKS_REG_W = 6;
	localparam int TAPS_REG_W  = 5;
	localparam int SCALE_W     = 16;
	localparam int SCALE_FRAC  = 12;
	// holds any bank or tap count up to 511
	localparam int COUNT_W     = 9;

	localparam logic [BANKS_REG_W-1:0]   BANKS_RST = BANKS_REG_W'(32);
	localparam logic [TAPS_REG_W-1:0]    TAPS_RST  = TAPS_REG_W'(16);
	localparam logic signed [SCALE_W-1:0] SCALE_RST = SCALE_W'(4096);

	typedef enum logic [OP_W-1:0] {
		OP_WRITE_COEF = 2'd0,
		OP_PUSH       = 2'd1,
		OP_EXECUTE    = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BANKS = 2'd0,
		CFG_TAPS  = 2'd1,
		CFG_SCALE = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_SHIFT  = 2'd1,
		CELL_ROTATE = 2'd2
	} cell_mode_t;

	typedef struct packed {
		logic step;
		logic use_tap;
		logic last;
	} mac_ctrl_t;

endpackage

/* hw/rtl/pfb_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfb_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pfb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 512
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/pfb_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfb_cell
// One sample slot of the window chain: holds, shifts in from the previous
// slot, or rotates in from the next slot.
// ----------------------------------------------------------------------------
module pfb_cell #(
	parameter int WIDTH = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  pfb_pkg::cell_mode_t       mode,
	input  logic [WIDTH-1:0]          prev_data,
	input  logic [WIDTH-1:0]          next_data,
	output logic [WIDTH-1:0]          data
);
	import pfb_pkg::*;

	logic [WIDTH-1:0] data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= '0;
		end else begin
			unique case (mode)
				CELL_SHIFT:  data_q <= prev_data;
				CELL_ROTATE: data_q <= next_data;
				default:     data_q <= data_q;
			endcase
		end
	end

	assign data = data_q;

endmodule

/* hw/rtl/pfb_mac.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfb_mac
// Multiply-accumulate over the taps, then Q15 rounding, output gain,
// rounding and saturation.
// ----------------------------------------------------------------------------
module pfb_mac #(
	parameter int SUB_TAPS   = 16,
	parameter int DATA_WIDTH = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  clear,
	input  logic                                  take,
	input  pfb_pkg::mac_ctrl_t                    ctrl,
	input  logic signed [DATA_WIDTH-1:0]          sample,
	input  logic signed [DATA_WIDTH-1:0]          coef,
	input  logic signed [pfb_pkg::SCALE_W-1:0]    scale,
	output logic                                  done,
	output logic signed [DATA_WIDTH-1:0]          result,
	output logic                                  sat
);
	import pfb_pkg::*;

	localparam int PROD_W = 2 * DATA_WIDTH;
	localparam int ACC_W  = PROD_W + $clog2(SUB_TAPS) + 1;
	localparam int FRAC   = DATA_WIDTH - 1;
	localparam int R1_W   = ACC_W + 1 - FRAC;
	localparam int M_W    = R1_W + SCALE_W;
	localparam int Y_W    = M_W + 1 - SCALE_FRAC;

	localparam logic signed [ACC_W:0] HALF1 = (ACC_W + 1)'(1) << (FRAC - 1);
	localparam logic signed [M_W:0]   HALF2 = (M_W + 1)'(1) << (SCALE_FRAC - 1);
	localparam logic signed [Y_W-1:0] Y_MAX =
		{{(Y_W - DATA_WIDTH + 1){1'b0}}, {(DATA_WIDTH - 1){1'b1}}};
	localparam logic signed [Y_W-1:0] Y_MIN =
		{{(Y_W - DATA_WIDTH + 1){1'b1}}, {(DATA_WIDTH - 1){1'b0}}};

	mac_ctrl_t                   ctrl_s1, ctrl_s2;
	logic signed [DATA_WIDTH-1:0] sample_s1;
	logic signed [PROD_W-1:0]    prod_s2;
	logic signed [ACC_W-1:0]     acc_q;
	logic                        done_s3;
	logic signed [R1_W-1:0]      r1_s4;
	logic                        v_s4;
	logic signed [M_W-1:0]       m_s5;
	logic                        v_s5;

	logic signed [ACC_W:0]       acc_rnd, acc_sh;
	logic signed [M_W:0]         m_rnd, m_sh;
	logic signed [Y_W-1:0]       y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
			done_s3 <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
		end else begin
			ctrl_s1 <= ctrl;
			ctrl_s2 <= ctrl_s1;
			done_s3 <= ctrl_s2.step && ctrl_s2.last;
			v_s4    <= done_s3;
			if (take) begin
				v_s5 <= 1'b0;
			end else if (v_s4) begin
				v_s5 <= 1'b1;
			end
		end
	end

	// coef arrives from the registered RAM read, aligned with sample_s1
	always_ff @(posedge clk) begin
		sample_s1 <= sample;
		prod_s2   <= coef * sample_s1;
		if (clear) begin
			acc_q <= '0;
		end else if (ctrl_s2.step && ctrl_s2.use_tap) begin
			acc_q <= acc_q + {{(ACC_W - PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
		end
		if (done_s3) begin
			r1_s4 <= acc_sh[R1_W-1:0];
		end
		if (v_s4) begin
			m_s5 <= r1_s4 * scale;
		end
	end

	assign acc_rnd = $signed({acc_q[ACC_W-1], acc_q}) + HALF1;
	assign acc_sh  = acc_rnd >>> FRAC;
	assign m_rnd   = $signed({m_s5[M_W-1], m_s5}) + HALF2;
	assign m_sh    = m_rnd >>> SCALE_FRAC;
	assign y       = m_sh[Y_W-1:0];

	always_comb begin
		priority if (y > Y_MAX) begin
			result = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
			sat    = 1'b1;
		end else if (y < Y_MIN) begin
			result = {1'b1, {(DATA_WIDTH - 1){1'b0}}};
			sat    = 1'b1;
		end else begin
			result = y[DATA_WIDTH-1:0];
			sat    = 1'b0;
		end
	end

	assign done = v_s5;

endmodule

/* hw/rtl/polyphase_fir_filter_bank.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyphase_fir_filter_bank
// Polyphase FIR bank: coefficient writes, sample pushes and sub-filter
// executes over a shared sample window held in a chain of cells.
// ----------------------------------------------------------------------------
// A coefficient write, a sample push and an unused operation leave the
// sequencer idle. An execute rotates the window once through the cell
// chain, one slot per cycle, while the coefficient RAM supplies one tap per
// cycle to a single multiply-accumulate; then the MAC pipeline drains and
// rounding, gain and saturation are applied. An execute on an inactive bank
// skips the rotation and the MAC. New transactions are taken while a
// finished result waits in the output register. The coefficient RAM has no
// reset and needs no clearing pass.
module polyphase_fir_filter_bank #(
	parameter int NUM_BANKS  = 32,
	parameter int SUB_TAPS   = 16,
	parameter int DATA_WIDTH = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [pfb_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [pfb_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [pfb_pkg::OP_W-1:0]               operation,
	input  logic [pfb_pkg::BANK_W-1:0]             bank,
	input  logic [pfb_pkg::TAP_W-1:0]              tap,
	input  logic signed [DATA_WIDTH-1:0]           coef_value,
	input  logic signed [DATA_WIDTH-1:0]           sample,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [DATA_WIDTH-1:0]           filtered,
	output logic                                   bank_error,
	output logic                                   saturated
);
	import pfb_pkg::*;

	localparam int RAM_DEPTH = NUM_BANKS * SUB_TAPS;
	localparam int RAM_AW    = RAM_DEPTH > 1 ? $clog2(RAM_DEPTH) : 1;
	localparam int K_W       = SUB_TAPS > 1 ? $clog2(SUB_TAPS) : 1;
	localparam logic [K_W-1:0] LAST_K = K_W'(SUB_TAPS - 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_WAIT = 3'b100
	} state_t;

	state_t                     state_q;
	logic [BANKS_REG_W-1:0]     banks_q;
	logic [TAPS_REG_W-1:0]      taps_q;
	logic signed [SCALE_W-1:0]  scale_q;
	logic [BANK_W-1:0]          bank_q;
	logic [COUNT_W-1:0]         nt_q;
	logic [K_W-1:0]             k_q;
	logic                       err_q;
	logic                       out_valid_q;
	logic signed [DATA_WIDTH-1:0] filtered_q;
	logic                       bank_error_q;
	logic                       saturated_q;

	logic                       in_fire, cfg_fire;
	logic [COUNT_W-1:0]         banks_ext, taps_ext, nb, nt;
	logic                       bank_bad, wr_ok;
	logic                       ram_we, ram_re;
	logic [RAM_AW-1:0]          ram_waddr, ram_raddr;
	logic [DATA_WIDTH-1:0]      ram_rdata;
	cell_mode_t                 cell_mode;
	logic [DATA_WIDTH-1:0]      cell_data [SUB_TAPS];
	mac_ctrl_t                  mac_ctrl;
	logic                       mac_done, mac_sat, mac_take;
	logic signed [DATA_WIDTH-1:0] mac_result;
	logic                       out_free, out_load;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;

	assign banks_ext = COUNT_W'(banks_q);
	assign taps_ext  = COUNT_W'(taps_q);
	assign nb        = (banks_ext < COUNT_W'(NUM_BANKS)) ? banks_ext : COUNT_W'(NUM_BANKS);
	assign nt        = (taps_ext < COUNT_W'(SUB_TAPS)) ? taps_ext : COUNT_W'(SUB_TAPS);
	assign bank_bad  = COUNT_W'(bank) >= nb;
	assign wr_ok     = (COUNT_W'(bank) < COUNT_W'(NUM_BANKS)) &&
	                   (COUNT_W'(tap) < COUNT_W'(SUB_TAPS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			banks_q <= BANKS_RST;
			taps_q  <= TAPS_RST;
			scale_q <= SCALE_RST;
		end else if (cfg_fire) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_BANKS: banks_q <= cfg_data[BANKS_REG_W-1:0];
				CFG_TAPS:  taps_q  <= cfg_data[TAPS_REG_W-1:0];
				CFG_SCALE: scale_q <= $signed(cfg_data[SCALE_W-1:0]);
				default:   ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			err_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire && (op_t'(operation) == OP_EXECUTE)) begin
						k_q <= '0;
						if (bank_bad) begin
							err_q   <= 1'b1;
							state_q <= ST_WAIT;
						end else begin
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					k_q <= k_q + K_W'(1);
					if (k_q == LAST_K) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (out_load) begin
						err_q   <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			bank_q <= bank;
			nt_q   <= nt;
		end
	end

	// coefficient memory
	assign ram_we    = in_fire && (op_t'(operation) == OP_WRITE_COEF) && wr_ok;
	assign ram_waddr = RAM_AW'(32'(bank) * SUB_TAPS + 32'(tap));
	assign ram_re    = (state_q == ST_RUN);
	assign ram_raddr = RAM_AW'(32'(bank_q) * SUB_TAPS + 32'(k_q));

	pfb_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (RAM_DEPTH)
	) u_coef_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (coef_value),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// sample window: push shifts toward the tail, execute rotates toward slot 0
	always_comb begin
		if (in_fire && (op_t'(operation) == OP_PUSH)) begin
			cell_mode = CELL_SHIFT;
		end else if (state_q == ST_RUN) begin
			cell_mode = CELL_ROTATE;
		end else begin
			cell_mode = CELL_HOLD;
		end
	end

	for (genvar i = 0; i < SUB_TAPS; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] prev_d, next_d;
		if (i == 0) begin : g_head
			assign prev_d = sample;
		end else begin : g_body
			assign prev_d = cell_data[i-1];
		end
		if (i == SUB_TAPS - 1) begin : g_tail
			assign next_d = cell_data[0];
		end else begin : g_mid
			assign next_d = cell_data[i+1];
		end
		pfb_cell #(
			.WIDTH (DATA_WIDTH)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.mode      (cell_mode),
			.prev_data (prev_d),
			.next_data (next_d),
			.data      (cell_data[i])
		);
	end

	// MAC
	always_comb begin
		mac_ctrl.step    = (state_q == ST_RUN);
		mac_ctrl.use_tap = COUNT_W'(k_q) < nt_q;
		mac_ctrl.last    = (k_q == LAST_K);
	end

	pfb_mac #(
		.SUB_TAPS   (SUB_TAPS),
		.DATA_WIDTH (DATA_WIDTH)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (in_fire),
		.take   (mac_take),
		.ctrl   (mac_ctrl),
		.sample (cell_data[0]),
		.coef   (ram_rdata),
		.scale  (scale_q),
		.done   (mac_done),
		.result (mac_result),
		.sat    (mac_sat)
	);

	// output register
	assign out_free = !out_valid_q || out_ready;
	assign out_load = (state_q == ST_WAIT) && (err_q || mac_done) && out_free;
	assign mac_take = out_load && !err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			filtered_q   <= err_q ? '0 : mac_result;
			bank_error_q <= err_q;
			saturated_q  <= err_q ? 1'b0 : mac_sat;
		end
	end

	assign out_valid  = out_valid_q;
	assign filtered   = filtered_q;
	assign bank_error = bank_error_q;
	assign saturated  = saturated_q;

	a_idle_mac_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !mac_done)
		else $error("MAC result pending while sequencer idle");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || out_ready))
		else $error("output register overwritten");

	a_run_full_turn: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_RUN) && (k_q == LAST_K)) |=> (state_q == ST_WAIT))
		else $error("window rotation not completed");

	a_err_no_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(bank_error_q && saturated_q))
		else $error("error transaction flagged saturated");

	a_err_skips_mac: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q && (state_q == ST_WAIT)) |-> !mac_done)
		else $error("MAC active during bank error transaction");

endmodule

/* test/polyphase_fir_filter_bank_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyphase_fir_filter_bank_test
// Self-checking bench for the polyphase FIR bank. A clocked driver feeds
// coefficient writes, sample pushes and executes from a queue, and a clocked
// monitor compares each output transaction with a bit-exact prediction of the
// fixed-point datapath. Register settings change between phases while idle;
// both sides insert random gaps, and one phase holds the output off long
// enough to back the block up into its input.
// ----------------------------------------------------------------------------
module polyphase_fir_filter_bank_test;
	import pfb_pkg::*;

	localparam int NB    = 32;
	localparam int NT    = 16;
	localparam int DW    = 16;
	localparam int LIMIT = 400000;
	localparam int TAIL  = 32;
	localparam int HOLD  = 400;
	localparam logic [OP_W-1:0]      OP_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_NONE  = 2'd3;

	typedef struct {
		logic [OP_W-1:0]      op;
		logic [BANK_W-1:0]    bank;
		logic [TAP_W-1:0]     tap;
		logic signed [DW-1:0] coef;
		logic signed [DW-1:0] smp;
	} fir_item_t;

	typedef struct packed {
		logic signed [DW-1:0] filtered;
		logic                 bank_error;
		logic                 saturated;
	} fir_result_t;

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  cfg_valid  = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index  = '0;
	logic [CFG_DATA_W-1:0] cfg_data   = '0;
	logic                  in_valid   = 1'b0;
	logic                  in_ready;
	logic [OP_W-1:0]       operation  = '0;
	logic [BANK_W-1:0]     bank       = '0;
	logic [TAP_W-1:0]      tap        = '0;
	logic signed [DW-1:0]  coef_value = '0;
	logic signed [DW-1:0]  sample     = '0;
	logic                  out_valid;
	logic                  out_ready  = 1'b0;
	logic signed [DW-1:0]  filtered;
	logic                  bank_error;
	logic                  saturated;

	polyphase_fir_filter_bank #(
		.NUM_BANKS(NB),
		.SUB_TAPS(NT),
		.DATA_WIDTH(DW)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.bank(bank),
		.tap(tap),
		.coef_value(coef_value),
		.sample(sample),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.filtered(filtered),
		.bank_error(bank_error),
		.saturated(saturated)
	);

	// predicted block state
	logic [BANKS_REG_W-1:0] m_banks = BANKS_RST;
	logic [TAPS_REG_W-1:0]  m_taps  = TAPS_RST;
	logic signed [SCALE_W-1:0] m_scale = SCALE_RST;
	logic signed [DW-1:0] m_coef [NB][NT];
	logic signed [DW-1:0] m_window [NT] = '{default: '0};
	bit coef_seen [NB][NT];

	fir_item_t   pending[$];
	fir_result_t results_due[$];
	fir_item_t   tx_item;
	fir_result_t want;

	int n_queued, n_accepted, n_checked, n_bank_err, n_sat, n_settings, fail_count;
	int tx_gap, rx_stall, rx_hold;
	bit tx_burst, rx_burst, hold_req;
	longint cycle_count;

	initial forever #2 clk = ~clk;

	function automatic void predict(input fir_item_t it);
		int nb, nt;
		longint acc, q, y;
		fir_result_t r;
		case (it.op)
			OP_WRITE_COEF: m_coef[it.bank][it.tap] = it.coef;
			OP_PUSH: begin
				for (int n = NT - 1; n > 0; n--)
					m_window[n] = m_window[n - 1];
				m_window[0] = it.smp;
			end
			OP_EXECUTE: begin
				nb = (m_banks > NB) ? NB : m_banks;
				nt = (m_taps > NT) ? NT : m_taps;
				r = '0;
				if (it.bank >= nb) begin
					r.bank_error = 1'b1;
				end else begin
					acc = 0;
					for (int n = 0; n < nt; n++)
						acc += longint'(m_coef[it.bank][n]) * longint'(m_window[n]);
					q = (acc + 64'sd16384) >>> 15;
					y = (q * longint'(m_scale) + 64'sd2048) >>> 12;
					if (y > 32767) begin
						y = 32767;
						r.saturated = 1'b1;
					end else if (y < -32768) begin
						y = -32768;
						r.saturated = 1'b1;
					end
					r.filtered = 16'(y);
				end
				results_due.push_back(r);
			end
			default: ;
		endcase
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			operation  <= '0;
			bank       <= '0;
			tap        <= '0;
			coef_value <= '0;
			sample     <= '0;
			tx_gap = 0;
		end else begin
			if (in_valid && in_ready) begin
				predict(tx_item);
				n_accepted++;
				tx_gap = tx_burst ? 0 : $urandom_range(0, 7);
			end
			if (!in_valid || in_ready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					in_valid <= 1'b0;
				end else if (pending.size() > 0) begin
					tx_item = pending.pop_front();
					operation  <= tx_item.op;
					bank       <= tx_item.bank;
					tap        <= tx_item.tap;
					coef_value <= tx_item.coef;
					sample     <= tx_item.smp;
					in_valid   <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_stall = 0;
			rx_hold = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (results_due.size() == 0) begin
					$error("output transaction with no execute pending: filtered %0d", filtered);
					fail_count++;
				end else begin
					want = results_due.pop_front();
					if (filtered !== want.filtered) begin
						$error("filtered: expected %0d, got %0d", want.filtered, filtered);
						fail_count++;
					end
					if (bank_error !== want.bank_error) begin
						$error("bank_error: expected %0d, got %0d", want.bank_error,
							bank_error);
						fail_count++;
					end
					if (saturated !== want.saturated) begin
						$error("saturated: expected %0d, got %0d", want.saturated, saturated);
						fail_count++;
					end
				end
				n_checked++;
				n_bank_err += bank_error;
				n_sat += saturated;
				rx_stall = rx_burst ? 0 : $urandom_range(0, 7);
			end
			if (hold_req) begin
				hold_req = 1'b0;
				rx_hold = HOLD;
			end
			if (rx_hold > 0) begin
				rx_hold--;
				out_ready <= 1'b0;
			end else if (rx_stall > 0) begin
				rx_stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT) begin
			$error("timed out after %0d cycles", cycle_count);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic int pick_word();
		case ($urandom_range(0, 7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_op(input logic [OP_W-1:0] op, input int b, input int t,
		input int c, input int s);
		fir_item_t it;
		it.op   = op;
		it.bank = b;
		it.tap  = t;
		it.coef = c;
		it.smp  = s;
		if (op == OP_WRITE_COEF)
			coef_seen[it.bank][it.tap] = 1'b1;
		pending.push_back(it);
		n_queued++;
	endtask

	// fills any tap the execute will read before issuing it
	task automatic queue_execute(input int b);
		int nb, nt;
		nb = (m_banks > NB) ? NB : m_banks;
		nt = (m_taps > NT) ? NT : m_taps;
		if (b < nb)
			for (int n = 0; n < nt; n++)
				if (!coef_seen[b][n])
					queue_op(OP_WRITE_COEF, b, n, pick_word(), $urandom);
		queue_op(OP_EXECUTE, b, $urandom, $urandom, $urandom);
	endtask

	task automatic queue_random(input int count);
		int done, r, b, nb;
		done = 0;
		while (done < count) begin
			nb = (m_banks > NB) ? NB : m_banks;
			r = $urandom_range(0, 19);
			if (r == 0) begin
				queue_op(OP_UNUSED, $urandom, $urandom, $urandom, $urandom);
			end else if (r < 6) begin
				queue_op(OP_WRITE_COEF, $urandom, $urandom, pick_word(), $urandom);
				done++;
			end else if (r < 13) begin
				queue_op(OP_PUSH, $urandom, $urandom, $urandom, pick_word());
				done++;
			end else begin
				b = (nb > 0 && $urandom_range(0, 7) != 0) ? $urandom_range(0, nb - 1) :
					$urandom_range(0, NB - 1);
				queue_execute(b);
				done++;
			end
		end
	endtask

	task automatic wait_idle();
		while (n_accepted != n_queued || results_due.size() != 0)
			@(posedge clk);
		repeat (TAIL) @(posedge clk);
	endtask

	// leaves cfg_valid high; the caller lowers it after the last write
	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_BANKS: m_banks = data[BANKS_REG_W-1:0];
			CFG_TAPS:  m_taps  = data[TAPS_REG_W-1:0];
			CFG_SCALE: m_scale = data;
			default: ;
		endcase
	endtask

	task automatic configure(input int banks, input int taps, input int scale,
		input bit stray = 1'b0);
		wait_idle();
		set_reg(CFG_BANKS, (16'($urandom) & 16'hFFC0) | 16'(banks));
		set_reg(CFG_TAPS, (16'($urandom) & 16'hFFE0) | 16'(taps));
		set_reg(CFG_SCALE, 16'(scale));
		if (stray)
			set_reg(CFG_NONE, $urandom);
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, saturation, bank limits, zero banks and taps
		configure(32, 2, 4096);
		queue_op(OP_WRITE_COEF, 0, 0, 16'h7FFF, $urandom);
		queue_op(OP_WRITE_COEF, 0, 1, 16'h8000, $urandom);
		queue_op(OP_WRITE_COEF, 31, 0, 16'h8000, $urandom);
		queue_op(OP_WRITE_COEF, 31, 1, 16'h8000, $urandom);
		queue_op(OP_WRITE_COEF, 17, 15, 16'h5A5A, $urandom);
		queue_op(OP_PUSH, $urandom, $urandom, $urandom, 16'h7FFF);
		queue_execute(0);
		queue_execute(31);
		queue_op(OP_PUSH, $urandom, $urandom, $urandom, 16'h8000);
		queue_execute(0);
		queue_op(OP_PUSH, $urandom, $urandom, $urandom, 16'h8000);
		queue_execute(31);
		queue_op(OP_UNUSED, $urandom, $urandom, $urandom, $urandom);
		queue_execute(31);
		queue_op(OP_PUSH, $urandom, $urandom, $urandom, 16'h0000);
		queue_execute(0);
		configure(1, 2, 32767);
		queue_execute(31);
		queue_execute(0);
		queue_op(OP_PUSH, $urandom, $urandom, $urandom, 16'h7FFF);
		queue_execute(0);
		configure(32, 2, -32768);
		queue_execute(31);
		queue_execute(0);
		configure(0, 0, 4096);
		queue_execute(0);
		configure(32, 0, 4096);
		queue_execute(5);

		// random phases
		configure(32, 16, 4096);
		queue_random(40);

		configure($urandom_range(1, 32), $urandom_range(1, 8), $urandom);
		tx_burst = 1'b1;
		hold_req = 1'b1;
		for (int i = 0; i < 20; i++)
			queue_execute($urandom_range(0, (m_banks > NB ? NB : m_banks) - 1));
		queue_random(30);
		wait_idle();
		tx_burst = 1'b0;

		configure(1, 1, 32767);
		queue_random(30);

		configure(0, 5, -32768);
		tx_burst = 1'b1;
		rx_burst = 1'b1;
		queue_random(20);
		wait_idle();
		tx_burst = 1'b0;
		rx_burst = 1'b0;

		configure($urandom_range(33, 63), $urandom_range(17, 31), $urandom, 1'b1);
		queue_random(40);

		configure($urandom_range(1, 32), 0, $urandom);
		queue_random(25);

		configure(16, 8, -1);
		queue_random(40);

		for (int p = 0; p < 3; p++) begin
			configure($urandom_range(1, 32), $urandom_range(1, 6), pick_word());
			queue_random(30);
		end

		wait_idle();
		$display("%0d input transactions over %0d register settings, %0d results checked",
			n_accepted, n_settings, n_checked);
		$display("%0d bank error results, %0d saturated results", n_bank_err, n_sat);
		if (fail_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
